// ----- hdl/dci_pkg.sv -----
// Shared types, codes and constants of the discount curve interpolator.
// Holds the square-root table of the base-2 exponential unit.
// Depends on nothing.
`default_nettype none

package dci_pkg;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [47:0] LOG2E_Q30  = 48'd1549082005;
    localparam logic [63:0] PRICE_NUM  = 64'h0000_4000_0000_0000;
    localparam logic [31:0] PRICE_SATL = 32'h0000_4000;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
    localparam logic [33:0] BASE_ONE   = 34'd268435456;

    typedef logic [31:0] t_root_tab [30];

    function automatic logic [63:0] isqrt64(input logic [63:0] a);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = a;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic t_root_tab root_table();
        logic [63:0] root;
        t_root_tab   tab;
        root = 64'd2 << 30;
        for (int i = 29; i >= 0; i--) begin
            root   = isqrt64(root << 30);
            tab[i] = root[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = root_table();

endpackage

`default_nettype wire

// ----- hdl/dci_ifs.sv -----
// Valid/ready channel interfaces: request items in, result items out.
// Stand-alone; no package needed.
`default_nettype none

interface dci_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic signed [31:0] time_req;
    logic [31:0] factor_in;
    modport source (output valid, op, time_req, factor_in, input ready);
    modport sink   (input valid, op, time_req, factor_in, output ready);
endinterface

interface dci_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] factor;
    logic [31:0] forward_price;
    logic [1:0]  status;
    modport source (output valid, factor, forward_price, status, input ready);
    modport sink   (input valid, factor, forward_price, status, output ready);
endinterface

`default_nettype wire

// ----- hdl/dci_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dci_ram #(
    parameter int W = 64,
    parameter int D = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]              o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/dci_mul.sv -----
// Sign-magnitude multiplier with truncating right shift and saturation to +-2^40.
// Works through the 48-bit first operand in 16-bit digits, then a finishing step shifts and saturates. Uses no package.
`default_nettype none

module dci_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_a,
    input  wire logic signed [47:0] i_b,
    input  wire logic [4:0]         i_sh,
    output logic                    o_done,
    output logic signed [41:0]      o_res
);

    localparam logic [87:0] SAT40 = 88'h1_0000_0000_00;

    logic [47:0] r_am;
    logic [39:0] r_bm;
    logic        r_neg;
    logic [4:0]  r_sh;
    logic [87:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic signed [41:0] r_res;

    logic [47:0] mag_a;
    logic [47:0] mag_b;
    logic [87:0] shifted;
    logic [40:0] mag_r;

    assign mag_a   = i_a[47] ? 48'(-i_a) : i_a;
    assign mag_b   = i_b[47] ? 48'(-i_b) : i_b;
    assign shifted = r_acc >> r_sh;
    assign mag_r   = (shifted > SAT40) ? SAT40[40:0] : shifted[40:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_am   <= mag_a;
                r_bm   <= mag_b[39:0];
                r_neg  <= i_a[47] ^ i_b[47];
                r_sh   <= i_sh;
            end else if (r_busy) begin
                r_acc <= (r_acc << 16) + 88'(r_am[47:32] * r_bm);
                r_am  <= r_am << 16;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= r_neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ----- hdl/dci_div.sv -----
// Restoring divider, one quotient bit a cycle, 32 quotient bits.
// Dividend high word must be below the divisor. Uses no package.
`default_nettype none

module dci_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quo
);

    logic [31:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_den;
    logic [31:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] trial;
    logic        fits;

    assign trial = {r_rem, r_lo[31]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num[63:32];
                r_lo   <= i_num[31:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                r_q   <= {r_q[30:0], fits};
                r_lo  <= r_lo << 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

// ----- hdl/dci_log.sv -----
// Base-2 logarithm in signed Q.30: normalise, then 30 squaring steps.
// Uses no package.
`default_nettype none

module dci_log (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_v,
    input  wire logic [4:0]  i_fb,
    output logic             o_done,
    output logic signed [37:0] o_res
);

    logic [31:0] r_x;
    logic [4:0]  r_sh;
    logic [4:0]  r_fb;
    logic [30:0] r_u;
    logic [29:0] r_frac;
    logic [4:0]  r_cnt;
    logic        r_norm;
    logic        r_busy;
    logic        r_done;

    logic [61:0] sq;
    logic [31:0] s2;
    logic [7:0]  ipart;

    assign sq    = 62'(r_u) * 62'(r_u);
    assign s2    = sq[61:30];
    assign ipart = 8'd31 - 8'(r_sh) - 8'(r_fb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_norm <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_norm <= 1'b1;
                r_x    <= i_v;
                r_sh   <= '0;
                r_fb   <= i_fb;
                r_cnt  <= '0;
            end else if (r_busy && r_norm) begin
                if (r_x[31]) begin
                    r_u    <= r_x[31:1];
                    r_norm <= 1'b0;
                end else if (r_x[31:24] == 8'd0) begin
                    r_x  <= r_x << 8;
                    r_sh <= r_sh + 5'd8;
                end else begin
                    r_x  <= r_x << 1;
                    r_sh <= r_sh + 5'd1;
                end
            end else if (r_busy) begin
                r_u    <= s2[31] ? s2[31:1] : s2[30:0];
                r_frac <= {r_frac[28:0], s2[31]};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd29) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = $signed({ipart, r_frac});

endmodule

`default_nettype wire

// ----- hdl/dci_exp.sv -----
// Base-2 exponential of a signed Q.30 exponent to an unsigned Q2.30 factor.
// 30 root-product steps and a rounding shift; uses ROOT_TAB from dci_pkg.
`default_nettype none

module dci_exp
    import dci_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_z,
    output logic                    o_done,
    output logic [31:0]             o_res
);

    localparam logic signed [47:0] Z_HI  = 48'sh0000_8000_0000;
    localparam logic signed [47:0] Z_LO  = 48'shFFF8_0000_0000;
    localparam logic [47:0]        Z_OFS = 48'h0008_0000_0000;

    logic [31:0] r_r;
    logic [29:0] r_f;
    logic [5:0]  r_e;
    logic [4:0]  r_i;
    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic [31:0] r_res;

    logic [47:0] zz;
    logic [63:0] prod;
    logic [5:0]  s;
    logic [32:0] t1;
    logic [32:0] v;

    assign zz   = 48'(i_z) + Z_OFS;
    assign prod = 64'(r_r) * 64'(ROOT_TAB[r_i]) + 64'h2000_0000;
    assign s    = 6'd32 - r_e;
    assign t1   = {1'b0, r_r} >> (s - 6'd1);

    always_comb begin
        if (r_e == 6'd33) begin
            v = {r_r, 1'b0};
        end else if (r_e == 6'd32) begin
            v = {1'b0, r_r};
        end else begin
            v = (t1 + 33'd1) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_fin <= 1'b0;
                if (i_z >= Z_HI) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= SAT32;
                end else if (i_z < Z_LO) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_e    <= zz[35:30];
                    r_f    <= zz[29:0];
                    r_r    <= ONE_Q30;
                    r_i    <= 5'd29;
                end
            end else if (r_busy) begin
                if (r_f[29]) begin
                    r_r <= prod[61:30];
                end
                r_f <= r_f << 1;
                r_i <= r_i - 5'd1;
                if (r_i == 5'd0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= v[32] ? SAT32 : v[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ----- hdl/discount_curve_interpolator.sv -----
// Discount curve interpolator: knot table in one RAM, sequencer and shared units.
// One item at a time; a new request is taken once the result is in the output register.
// Query: knot scan of one RAM read a cycle, up to two logarithms, two divides, a
// multiply and an exponential. Load: knot scan, then a one-port shift and the insert.
// Clear: resets the knot count. Sync active-low reset empties the table.
`default_nettype none

module discount_curve_interpolator
    import dci_pkg::*;
#(
    parameter int MAX_KNOTS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dci_req_if.sink          i_req,
    dci_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = $clog2(MAX_KNOTS);
    localparam int CW = $clog2(MAX_KNOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN0, S_SCAN, S_SHRD, S_SHWR, S_INS,
        S_FMUL1, S_FMUL2, S_DIVY, S_LOGB, S_MULB,
        S_LOG0, S_LOG1, S_DIVW, S_MULW, S_EXP, S_PRICE, S_FIN
    } t_state;

    t_state r_state;
    logic   r_go;

    logic [31:0] r_y;
    logic [3:0]  r_m;
    logic [CW-1:0] r_count;

    logic [1:0]  r_op;
    logic signed [31:0] r_t;
    logic [31:0] r_fin;
    logic [IW-1:0] r_k;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_i;
    logic [63:0] r_prev;
    logic signed [31:0] r_t0;
    logic signed [31:0] r_t1;
    logic [31:0] r_f1;
    logic signed [37:0] r_l0;
    logic signed [37:0] r_l1;
    logic [31:0] r_df;
    logic [31:0] r_price;
    logic [1:0]  r_status;

    logic signed [47:0] r_ma;
    logic signed [47:0] r_mb;
    logic [4:0]  r_msh;
    logic [63:0] r_dnum;
    logic [31:0] r_dden;
    logic [31:0] r_lv;
    logic [4:0]  r_lfb;
    logic signed [47:0] r_ez;

    logic        r_o_valid;
    logic [31:0] r_o_factor;
    logic [31:0] r_o_price;
    logic [1:0]  r_o_status;

    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    logic [63:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [63:0] ram_rdata;

    logic        mul_done;
    logic signed [41:0] mul_res;
    logic        div_done;
    logic [31:0] div_quo;
    logic        log_done;
    logic signed [37:0] log_res;
    logic        exp_done;
    logic [31:0] exp_res;

    logic signed [31:0] rt;
    logic [31:0] rf;
    logic        cont;
    logic        last;
    logic signed [33:0] qy;
    logic signed [33:0] base;
    logic [35:0] mt;
    logic        cfg_wr;

    assign rt   = $signed(ram_rdata[63:32]);
    assign rf   = ram_rdata[31:0];
    assign cont = (r_op == OP_QUERY) ? (rt < r_t) : (rt <= r_t);
    assign last = (CW'(r_k) + CW'(1)) == r_count;
    assign qy   = r_y[31] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign base = $signed(BASE_ONE) + qy;
    assign mt   = 36'(r_m) * 36'(r_t[30:0]);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        case (r_state)
            S_SCAN:  ram_raddr = r_k + IW'(1);
            S_SHRD:  ram_raddr = IW'(r_i - CW'(1));
            S_SHWR:  ram_we = 1'b1;
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[IW-1:0];
                ram_wdata = {r_t, r_fin};
            end
            default: ram_raddr = '0;
        endcase
    end

    dci_ram #(.W(64), .D(MAX_KNOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dci_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_FMUL1 || r_state == S_FMUL2 ||
                           r_state == S_MULB || r_state == S_MULW)),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .i_sh    (r_msh),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    dci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_DIVY || r_state == S_DIVW ||
                           r_state == S_PRICE)),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    dci_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_LOGB || r_state == S_LOG0 ||
                           r_state == S_LOG1)),
        .i_v     (r_lv),
        .i_fb    (r_lfb),
        .o_done  (log_done),
        .o_res   (log_res)
    );

    dci_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && r_state == S_EXP),
        .i_z     (r_ez),
        .o_done  (exp_done),
        .o_res   (exp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_o_valid && o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= i_req.op;
                        r_t      <= i_req.time_req;
                        r_fin    <= i_req.factor_in;
                        r_df     <= '0;
                        r_price  <= '0;
                        r_status <= ST_OK;
                        case (i_req.op)
                            OP_QUERY: begin
                                if (i_req.time_req <= 0) begin
                                    r_df    <= ONE_Q30;
                                    r_dden  <= ONE_Q30;
                                    r_dnum  <= PRICE_NUM;
                                    r_go    <= 1'b1;
                                    r_state <= S_PRICE;
                                end else if (r_count == '0) begin
                                    r_go <= 1'b1;
                                    if (r_m == 4'd0) begin
                                        r_ma    <= 48'(signed'(r_y));
                                        r_mb    <= 48'(i_req.time_req);
                                        r_msh   <= 5'd22;
                                        r_state <= S_FMUL1;
                                    end else begin
                                        r_dnum  <= {32'd0, r_y[31] ? 32'(-r_y) : r_y};
                                        r_dden  <= {28'd0, r_m};
                                        r_state <= S_DIVY;
                                    end
                                end else begin
                                    r_state <= S_SCAN0;
                                end
                            end
                            OP_LOAD: begin
                                if (i_req.time_req <= 0 || i_req.factor_in == '0) begin
                                    r_status <= ST_INVALID;
                                    r_state  <= S_FIN;
                                end else if (r_count >= CW'(MAX_KNOTS)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FIN;
                                end else if (r_count == '0) begin
                                    r_pos   <= '0;
                                    r_i     <= '0;
                                    r_state <= S_SHRD;
                                end else begin
                                    r_state <= S_SCAN0;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FIN;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_SCAN0: begin
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_prev <= ram_rdata;
                    if (cont && !last) begin
                        r_k <= r_k + IW'(1);
                    end else if (r_op == OP_LOAD) begin
                        r_pos   <= cont ? r_count : CW'(r_k);
                        r_i     <= r_count;
                        r_state <= S_SHRD;
                    end else if (cont || r_k == '0 || r_t == rt ||
                                 rt <= $signed(r_prev[63:32])) begin
                        if (!cont && r_k != '0 && r_t != rt) begin
                            r_df   <= r_prev[31:0];
                            r_dden <= r_prev[31:0];
                        end else begin
                            r_df   <= rf;
                            r_dden <= rf;
                        end
                        r_dnum  <= PRICE_NUM;
                        r_go    <= 1'b1;
                        r_state <= S_PRICE;
                    end else begin
                        r_t0    <= $signed(r_prev[63:32]);
                        r_t1    <= rt;
                        r_f1    <= rf;
                        r_lv    <= r_prev[31:0];
                        r_lfb   <= 5'd30;
                        r_go    <= 1'b1;
                        r_state <= S_LOG0;
                    end
                end
                S_SHRD: begin
                    r_state <= (r_i == r_pos) ? S_INS : S_SHWR;
                end
                S_SHWR: begin
                    r_i     <= r_i - CW'(1);
                    r_state <= S_SHRD;
                end
                S_INS: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_FIN;
                end
                S_FMUL1: begin
                    if (!r_go && mul_done) begin
                        r_ma    <= -48'(mul_res);
                        r_mb    <= LOG2E_Q30;
                        r_msh   <= 5'd30;
                        r_go    <= 1'b1;
                        r_state <= S_FMUL2;
                    end
                end
                S_FMUL2: begin
                    if (!r_go && mul_done) begin
                        r_ez    <= 48'(mul_res);
                        r_go    <= 1'b1;
                        r_state <= S_EXP;
                    end
                end
                S_DIVY: begin
                    if (!r_go && div_done) begin
                        if (base <= 0) begin
                            r_df    <= '0;
                            r_state <= S_PRICE;
                        end else begin
                            r_lv    <= base[31:0];
                            r_lfb   <= 5'd28;
                            r_go    <= 1'b1;
                            r_state <= S_LOGB;
                        end
                    end
                end
                S_LOGB: begin
                    if (!r_go && log_done) begin
                        r_ma    <= -48'(mt);
                        r_mb    <= 48'(log_res);
                        r_msh   <= 5'd24;
                        r_go    <= 1'b1;
                        r_state <= S_MULB;
                    end
                end
                S_MULB: begin
                    if (!r_go && mul_done) begin
                        r_ez    <= 48'(mul_res);
                        r_go    <= 1'b1;
                        r_state <= S_EXP;
                    end
                end
                S_LOG0: begin
                    if (!r_go && log_done) begin
                        r_l0    <= log_res;
                        r_lv    <= r_f1;
                        r_lfb   <= 5'd30;
                        r_go    <= 1'b1;
                        r_state <= S_LOG1;
                    end
                end
                S_LOG1: begin
                    if (!r_go && log_done) begin
                        r_l1    <= log_res;
                        r_dnum  <= {2'b00, 32'(r_t - r_t0), 30'd0};
                        r_dden  <= 32'(r_t1 - r_t0);
                        r_go    <= 1'b1;
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (!r_go && div_done) begin
                        r_ma    <= 48'(r_l1) - 48'(r_l0);
                        r_mb    <= 48'(div_quo);
                        r_msh   <= 5'd30;
                        r_go    <= 1'b1;
                        r_state <= S_MULW;
                    end
                end
                S_MULW: begin
                    if (!r_go && mul_done) begin
                        r_ez    <= 48'(r_l0) + 48'(mul_res);
                        r_go    <= 1'b1;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (!r_go && exp_done) begin
                        r_df    <= exp_res;
                        r_dden  <= exp_res;
                        r_dnum  <= PRICE_NUM;
                        r_go    <= 1'b1;
                        r_state <= S_PRICE;
                    end
                end
                S_PRICE: begin
                    if (r_df == '0) begin
                        r_price <= '0;
                        r_state <= S_FIN;
                    end else if (r_df <= PRICE_SATL) begin
                        r_price <= SAT32;
                        r_state <= S_FIN;
                    end else if (!r_go && div_done) begin
                        r_price <= div_quo;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_factor <= r_df;
                        r_o_price  <= r_price;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y <= '0;
            r_m <= '0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_m <= pwdata[3:0];
            end else begin
                r_y <= pwdata;
            end
        end
    end

    assign prdata = paddr[2] ? {28'd0, r_m} : r_y;
    assign pready = 1'b1;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.factor        = r_o_factor;
    assign o_rsp.forward_price = r_o_price;
    assign o_rsp.status        = r_o_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KNOTS))
        else $error("knot count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
        (r_count == '0))
        else $error("knot count moved other than by one insertion or a clear");

    a_price_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.factor == '0) |-> (o_rsp.forward_price == '0))
        else $error("nonzero price for zero factor");

    a_ram_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

endmodule

`default_nettype wire
